@@ hdl/rtki_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtki_pkg
// Shared types and constants for the ranked top-k insertion table.
// ----------------------------------------------------------------------------
package rtki_pkg;

  localparam int SCORE_W     = 31;
  localparam int LEVEL_W     = 16;
  localparam int TAG_W       = 3;
  localparam int RANK_W      = 3;
  localparam int RANK_SPAN   = 1 << RANK_W;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [LEVEL_W-1:0] level;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

endpackage

@@ hdl/ranked_top_k_insert_top.sv @@
`timescale 1ns / 1ps
// A result is valid the cycle after its request is accepted.
// Throughput: one request per cycle; every slot compares in parallel and
// the cell row shifts in the same edge. A stalled result holds the input.
// Reset (synchronous, active low) clears every slot to zero and drops any
// pending result.
// ----------------------------------------------------------------------------
// ranked_top_k_insert_top
// Sorted top-k table built as a row of compare/shift cells, with a read port
// and a registered result stage.
// ----------------------------------------------------------------------------
module ranked_top_k_insert_top #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // cand_score[30:0], cand_level[46:31], cand_tag[49:47], read_rank[52:50]
  input  logic [rtki_pkg::IN_TDATA_W-1:0]   in_tdata,
  // command
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // rank[2:0], entry_score[33:3], entry_level[49:34], entry_tag[52:50]
  output logic [rtki_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // placed
  output logic                              out_tuser
);
  import rtki_pkg::*;

  entry_t                 cand;
  logic [RANK_W-1:0]      read_rank;
  cmd_t                   cmd;
  logic                   in_fire;
  logic                   ins_en;

  entry_t                 ent [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] win;
  logic [TABLE_DEPTH:0]   win_ext;
  logic [TABLE_DEPTH-1:0] first;

  logic                   res_placed;
  logic [RANK_W-1:0]      res_rank;
  entry_t                 res_ent;

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tuser_r;

  assign cand.score = in_tdata[SCORE_W-1:0];
  assign cand.level = in_tdata[SCORE_W+LEVEL_W-1:SCORE_W];
  assign cand.tag   = in_tdata[SCORE_W+LEVEL_W+TAG_W-1:SCORE_W+LEVEL_W];
  assign read_rank  = in_tdata[SCORE_W+LEVEL_W+TAG_W+RANK_W-1:SCORE_W+LEVEL_W+TAG_W];
  assign cmd        = cmd_t'(in_tuser);

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign ins_en    = in_fire && (cmd == CMD_INSERT);

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      rtki_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (ins_en),
        .cand     (cand),
        .prev_win (1'b0),
        .prev_ent (cand),
        .win      (win[g]),
        .ent      (ent[g])
      );
    end else begin : g_body
      rtki_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (ins_en),
        .cand     (cand),
        .prev_win (win[g-1]),
        .prev_ent (ent[g-1]),
        .win      (win[g]),
        .ent      (ent[g])
      );
    end
  end

  // table is kept sorted, so win is a thermometer; first marks its edge
  assign win_ext = {win, 1'b0};
  assign first   = win & ~win_ext[TABLE_DEPTH-1:0];

  always_comb begin
    res_placed = 1'b0;
    res_rank   = '0;
    res_ent    = '0;
    unique case (cmd)
      CMD_READ: begin
        res_rank = read_rank;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if ((i < RANK_SPAN) && (read_rank == RANK_W'(i))) begin
            res_ent = res_ent | ent[i];
          end
        end
      end
      CMD_INSERT: begin
        res_placed = |win;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (first[i]) begin
            res_rank = res_rank | RANK_W'(i);
          end
        end
        if (res_placed) begin
          res_ent = cand;
        end
      end
      default: begin
        res_placed = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= OUT_TDATA_W'({res_ent.tag, res_ent.level, res_ent.score, res_rank});
      out_tuser_r <= res_placed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_win_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    (win_ext[TABLE_DEPTH-1:0] & ~win) == '0)
    else $error("win vector not monotone: table out of order");

  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first))
    else $error("more than one insert slot selected");

  a_insert_placed: assert property (@(posedge clk) disable iff (!rst_n)
    (ins_en && (|win)) |=> (out_tvalid && out_tuser))
    else $error("winning insert not reported as placed");

  a_read_unplaced: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (cmd == CMD_READ)) |=> (out_tvalid && !out_tuser))
    else $error("read reported as placed");

endmodule

@@ hdl/rtki_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtki_cell
// One table slot: holds an entry, compares it against the candidate and
// takes either the upper neighbor's entry or the candidate on an insert.
// ----------------------------------------------------------------------------
module rtki_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  rtki_pkg::entry_t cand,
  input  logic            prev_win,
  input  rtki_pkg::entry_t prev_ent,
  output logic            win,
  output rtki_pkg::entry_t ent
);
  import rtki_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  assign win = (cand.score > ent_r.score) ||
               ((cand.score == ent_r.score) && (cand.level > ent_r.level));
  assign ent = ent_r;

  always_comb begin
    priority if (shift_en && prev_win) begin
      ent_nxt = prev_ent;
    end else if (shift_en && win) begin
      ent_nxt = cand;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the ranked top-k table against a mirror of its slots. Every accepted
// request queues the result the table should give; every accepted result is
// compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module tb;
  import rtki_pkg::*;

  localparam int TABLE_DEPTH = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_REQS = 950;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  typedef struct packed {
    logic [IN_TDATA_W-SCORE_W-LEVEL_W-TAG_W-RANK_W-1:0] pad;
    logic [RANK_W-1:0]                                    read_rank;
    entry_t                                               cand;
  } request_t;

  typedef struct packed {
    logic [OUT_TDATA_W-$bits(entry_t)-RANK_W-1:0] pad;
    entry_t                                       entry;
    logic [RANK_W-1:0]                            rank;
  } result_t;

  typedef struct packed {
    logic    placed;
    result_t data;
  } outcome_t;

  class ranked_table_board;
    entry_t   mirror_table [TABLE_DEPTH];
    outcome_t expected_results[$];
    int       mismatches;

    function new();
      foreach (mirror_table[i]) mirror_table[i] = '0;
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
    endtask

    function void note_request(cmd_t cmd, request_t req);
      outcome_t res;
      int       slot;
      res  = '0;
      slot = TABLE_DEPTH;
      if (cmd == CMD_READ) begin
        res.data.rank = req.read_rank;
        if (req.read_rank < TABLE_DEPTH) res.data.entry = mirror_table[req.read_rank];
      end else begin
        // first slot the candidate strictly beats; ties on both keys go below
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
          if (req.cand.score > mirror_table[i].score ||
              (req.cand.score == mirror_table[i].score &&
               req.cand.level > mirror_table[i].level)) slot = i;
        end
        if (slot < TABLE_DEPTH) begin
          for (int j = TABLE_DEPTH - 1; j > slot; j--) mirror_table[j] = mirror_table[j-1];
          mirror_table[slot] = req.cand;
          res.placed     = 1'b1;
          res.data.rank  = slot[RANK_W-1:0];
          res.data.entry = req.cand;
        end
      end
      expected_results.push_back(res);
    endfunction

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] tdata, logic placed);
      outcome_t want;
      result_t  got;
      got = result_t'(tdata);
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending");
        return;
      end
      want = expected_results.pop_front();
      check_field("placed", 32'(placed), 32'(want.placed));
      check_field("rank", 32'(got.rank), 32'(want.data.rank));
      check_field("entry_score", 32'(got.entry.score), 32'(want.data.entry.score));
      check_field("entry_level", 32'(got.entry.level), 32'(want.data.entry.level));
      check_field("entry_tag", 32'(got.entry.tag), 32'(want.data.entry.tag));
    endtask
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  ranked_table_board board;
  bit                gaps_on = 1'b1;
  int                quiet_cycles = 0;

  ranked_top_k_insert_top #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
    out_tready <= !(gaps_on && $urandom_range(0, 99) < 29);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a rising edge; returns at the edge that accepted the request
  task automatic send_request(input cmd_t cmd, input logic [SCORE_W-1:0] score,
                              input logic [LEVEL_W-1:0] level,
                              input logic [TAG_W-1:0] tag,
                              input logic [RANK_W-1:0] read_rank);
    request_t req;
    req           = '0;
    req.cand      = '{tag: tag, level: level, score: score};
    req.read_rank = read_rank;
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(cmd, req);
  endtask

  task automatic send_read(input logic [RANK_W-1:0] read_rank);
    send_request(CMD_READ, SCORE_W'($urandom), LEVEL_W'($urandom), TAG_W'($urandom),
                 read_rank);
  endtask

  task automatic send_insert(input logic [SCORE_W-1:0] score,
                             input logic [LEVEL_W-1:0] level,
                             input logic [TAG_W-1:0] tag);
    send_request(CMD_INSERT, score, level, tag, RANK_W'($urandom));
  endtask

  initial begin
    logic [SCORE_W-1:0] base;
    entry_t             last_cand;
    int                 pick;

    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_read(0);
    send_read(7);
    send_insert(0, 0, 0);                 // ties the cleared slots: not placed
    send_insert(0, 1, 5);
    send_insert(0, 1, 2);                 // equal entry lands below
    send_insert(0, LEVEL_MAX, 3);         // score tie, level decides
    send_insert(SCORE_MAX, LEVEL_MAX, 7);
    send_insert(SCORE_MAX, 0, 1);
    send_insert(1000, 7, 4);
    send_insert(1000, 7, 6);
    send_insert(999, LEVEL_MAX, 0);
    for (int r = 0; r < TABLE_DEPTH; r++) send_read(RANK_W'(r));
    send_request(CMD_READ, SCORE_MAX, LEVEL_MAX, '1, '1);
    send_insert(0, 0, 7);

    base      = SCORE_W'(32'h4000_0000 | ($urandom & 32'h3FF0_0000));
    last_cand = '{tag: 0, level: 0, score: base};
    for (int n = 0; n < RANDOM_REQS; n++) begin
      gaps_on = !(n >= 200 && n < 350);
      if (n == RANDOM_REQS / 2) begin
        in_tvalid <= 1'b0;
        while (board.expected_results.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_read(RANK_W'($urandom));
      end else if (pick < 45) begin
        send_insert(SCORE_W'($urandom_range(0, base)), LEVEL_W'($urandom), TAG_W'($urandom));
      end else if (pick < 55) begin
        send_insert(last_cand.score, last_cand.level, TAG_W'($urandom));
      end else begin
        last_cand.score = SCORE_W'(base - SCORE_W'(8) + SCORE_W'($urandom_range(0, 11)));
        last_cand.level = LEVEL_W'($urandom_range(0, 3));
        last_cand.tag   = TAG_W'($urandom);
        send_insert(last_cand.score, last_cand.level, last_cand.tag);
        base = base + SCORE_W'($urandom_range(0, 2));
      end
    end
    in_tvalid <= 1'b0;
    gaps_on = 1'b1;

    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
